// ===== hw/rtl/eic_pkg.sv =====
package eic_pkg;

   // Line and port geometry.
   localparam int NUM_LINES = 16;
   localparam int NUM_PORTS = 3;
   localparam int WORD_BITS = 16;
   localparam int SEL_BITS  = 4;
   localparam int SEL_WIDTH = WORD_BITS * SEL_BITS;

   // Lines that exist: below both NUM_LINES and the word width.
   localparam logic [WORD_BITS-1:0] LINES_PRESENT =
      (NUM_LINES >= WORD_BITS) ? {WORD_BITS{1'b1}} :
      WORD_BITS'((33'd1 << NUM_LINES) - 33'd1);

   // Operation codes.
   localparam logic [1:0] OP_SAMPLE = 2'd0;
   localparam logic [1:0] OP_READ   = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   // Port select codes.
   localparam logic [SEL_BITS-1:0] SEL_PORT_A = 4'd0;
   localparam logic [SEL_BITS-1:0] SEL_PORT_B = 4'd1;
   localparam logic [SEL_BITS-1:0] SEL_PORT_C = 4'd2;

   // CSR register indexes.
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INTERRUPT_MASK     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RISING_ENABLE      = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FALLING_ENABLE     = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_SOURCE_SELECT = 2'd3;

   // One captured request transaction.
   typedef struct packed {
      logic [1:0]           operation;
      logic [3:0]           line;
      logic [WORD_BITS-1:0] port_a_levels;
      logic [WORD_BITS-1:0] port_b_levels;
      logic [WORD_BITS-1:0] port_c_levels;
   } eic_item_type;

   // Per-line trigger and mask setup.
   typedef struct packed {
      logic [WORD_BITS-1:0] interrupt_mask;
      logic [WORD_BITS-1:0] rising_enable;
      logic [WORD_BITS-1:0] falling_enable;
   } eic_trigger_type;

   // One response transaction.
   typedef struct packed {
      logic                 pending_bit;
      logic [WORD_BITS-1:0] pending_lines;
      logic [WORD_BITS-1:0] irq_lines;
   } eic_result_type;

endpackage

// ===== hw/rtl/eic_line_router.sv =====
module eic_line_router
   import eic_pkg::*;
(
   input  logic [SEL_WIDTH-1:0] line_source_select,
   input  logic [WORD_BITS-1:0] port_a_levels,
   input  logic [WORD_BITS-1:0] port_b_levels,
   input  logic [WORD_BITS-1:0] port_c_levels,
   output logic [WORD_BITS-1:0] line_levels
);

   always_comb begin
      logic [SEL_BITS-1:0] sel;
      line_levels = '0;
      for (int n = 0; n < WORD_BITS; n++) begin
         sel = line_source_select[n*SEL_BITS +: SEL_BITS];
         if (32'(sel) < NUM_PORTS) begin
            case (sel)
               SEL_PORT_A: line_levels[n] = port_a_levels[n];
               SEL_PORT_B: line_levels[n] = port_b_levels[n];
               SEL_PORT_C: line_levels[n] = port_c_levels[n];
               default:    line_levels[n] = 1'b0;
            endcase
         end
      end
      // non-existent lines stay low
      line_levels = line_levels & LINES_PRESENT;
   end

endmodule

// ===== hw/rtl/eic_pending_unit.sv =====
module eic_pending_unit
   import eic_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic [1:0]           operation,
   input  logic [3:0]           line,
   input  logic [WORD_BITS-1:0] line_levels,
   input  eic_trigger_type      trigger,
   output eic_result_type       result
);

   logic [WORD_BITS-1:0] previous_levels_ff, previous_levels_in;
   logic [WORD_BITS-1:0] pending_ff, pending_in;
   logic                 line_ok;
   logic [WORD_BITS-1:0] rise, fall;

   assign line_ok = 32'(line) < NUM_LINES;
   assign rise    = line_levels & ~previous_levels_ff & trigger.rising_enable;
   assign fall    = ~line_levels & previous_levels_ff & trigger.falling_enable;

   always_comb begin
      previous_levels_in = previous_levels_ff;
      pending_in         = pending_ff;
      result.pending_bit = 1'b0;
      case (operation)
         OP_SAMPLE: begin
            pending_in         = (pending_ff | rise | fall) & LINES_PRESENT;
            previous_levels_in = line_levels & LINES_PRESENT;
         end
         OP_READ: begin
            if (line_ok) begin
               result.pending_bit = pending_ff[line];
            end
         end
         OP_CLEAR: begin
            if (line_ok) begin
               pending_in = pending_ff & ~(WORD_BITS'(1) << line);
            end
         end
         default: ;
      endcase
      result.pending_lines = pending_in;
      result.irq_lines     = pending_in & trigger.interrupt_mask;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         previous_levels_ff <= '0;
         pending_ff         <= '0;
      end else if (advance) begin
         previous_levels_ff <= previous_levels_in;
         pending_ff         <= pending_in;
      end
   end

endmodule

// ===== hw/rtl/external_interrupt_edge_controller.sv =====
// Channel  | Handshake         | Payload
// ---------+-------------------+-------------------------------------------------
// req      | req_valid/stall   | operation, line, port_a/b/c_levels
// rsp      | rsp_valid/stall   | pending_bit, pending_lines, irq_lines
// csr      | csr_valid/ready   | csr_index (0 mask, 1 rise, 2 fall, 3 select), data
//
// One transaction per cycle sustained while rsp is not stalled; rsp_valid
// rises once the accepted request has passed the input register and then
// the result register.
// Edge detect, pending update and mask all sit in one combinational pass
// between the two registers; the pending state updates as the item moves on.
// Synchronous active-high reset clears pending, last levels and all CSRs.
// A stalled response holds; the input register still takes one more request,
// and req_stall rises only when both registers are full and rsp is stalled.
// CSR writes are always ready and are expected only while the block is idle.
module external_interrupt_edge_controller
   import eic_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_operation,
   input  logic [3:0]                req_line,
   input  logic [WORD_BITS-1:0]      req_port_a_levels,
   input  logic [WORD_BITS-1:0]      req_port_b_levels,
   input  logic [WORD_BITS-1:0]      req_port_c_levels,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_pending_bit,
   output logic [WORD_BITS-1:0]      rsp_pending_lines,
   output logic [WORD_BITS-1:0]      rsp_irq_lines,

   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [SEL_WIDTH-1:0]      csr_data
);

   // CSRs
   eic_trigger_type      trigger_ff;
   logic [SEL_WIDTH-1:0] line_source_select_ff;

   // input stage
   logic         item_valid_ff;
   eic_item_type item_ff;

   // result stage
   logic           rsp_valid_ff;
   eic_result_type rsp_ff;

   logic           advance;
   logic           req_accept;
   logic [WORD_BITS-1:0] line_levels;
   eic_result_type result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         trigger_ff            <= '0;
         line_source_select_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_INTERRUPT_MASK:     trigger_ff.interrupt_mask <= csr_data[WORD_BITS-1:0];
            CSR_RISING_ENABLE:      trigger_ff.rising_enable  <= csr_data[WORD_BITS-1:0];
            CSR_FALLING_ENABLE:     trigger_ff.falling_enable <= csr_data[WORD_BITS-1:0];
            CSR_LINE_SOURCE_SELECT: line_source_select_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // Item moves from input register to result register when the latter is
   // free or being drained this cycle.
   assign advance    = item_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = item_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_accept) begin
         item_valid_ff <= 1'b1;
      end else if (advance) begin
         item_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff.operation     <= req_operation;
         item_ff.line          <= req_line;
         item_ff.port_a_levels <= req_port_a_levels;
         item_ff.port_b_levels <= req_port_b_levels;
         item_ff.port_c_levels <= req_port_c_levels;
      end
   end

   eic_line_router u_router (
      .line_source_select (line_source_select_ff),
      .port_a_levels      (item_ff.port_a_levels),
      .port_b_levels      (item_ff.port_b_levels),
      .port_c_levels      (item_ff.port_c_levels),
      .line_levels        (line_levels)
   );

   eic_pending_unit u_pending (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .operation   (item_ff.operation),
      .line        (item_ff.line),
      .line_levels (line_levels),
      .trigger     (trigger_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pending_bit   = rsp_ff.pending_bit;
   assign rsp_pending_lines = rsp_ff.pending_lines;
   assign rsp_irq_lines     = rsp_ff.irq_lines;

endmodule
